// ===== design/assert_macros.svh =====
// Assertion helpers shared by the top, column store and pending counter files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on an explicit clock, muted while reset is high.
`define DTS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check on the house clock and reset names.
`define DTS_ASSERT(label, prop, msg) \
   `DTS_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== design/dts_pkg.sv =====
`timescale 1ns / 1ps

package dts_pkg;

   localparam int SLOTS      = 16;
   localparam int NODES      = 16;
   localparam int LIVE_NODES = (NODES < SLOTS) ? NODES : SLOTS;
   localparam int IDX_W      = $clog2(SLOTS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int MASK_W     = SLOTS;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_SORT  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_ADD     = 9'b000000010,
      S_COUNT   = 9'b000000100,
      S_SEED    = 9'b000001000,
      S_PICK    = 9'b000010000,
      S_RELEASE = 9'b000100000,
      S_FINISH  = 9'b001000000,
      S_EMIT    = 9'b010000000,
      S_DRAIN   = 9'b100000000
   } state_type;

   // commands from the sequencer to the pending counters
   typedef struct packed {
      logic             init;
      logic             count_en;
      logic             seed;
      logic             release_en;
      logic             take_en;
      logic [IDX_W-1:0] take_node;
   } pend_cmd_type;

   // priority encoder, lowest set bit wins
   function automatic logic [IDX_W-1:0] lowest_set(input logic [MASK_W-1:0] mask);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (mask[i]) pos = IDX_W'(i);
      end
      return pos;
   endfunction

endpackage

// ===== design/dependency_topological_sort_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   | Ports                                     | Transfer
// ----------+-------------------------------------------+---------------------------------
// request   | start, busy, req_op, req_module_index,    | taken when start && !busy
//           | req_uses_mask                             |
// result    | rsp_strobe, rsp_module_out, rsp_last,     | one result per cycle, strobed,
//           | rsp_cycle_found, rsp_blocked_mask,        | no back-pressure
//           | rsp_empty_graph                           |
//
// Request steps: clear and a sort on an empty graph finish on acceptance; add is a
// read-modify-write sweep of the 16 column entries through one read and one write port.
// Other sorts: accept, count sweep, seed, then pick and release per ordered module, a
// last pick and finish; a cycle result ends it there, else one emit per result and a drain.
// Reset is synchronous and empties the graph at once through per-entry valid bits.
// busy stays high while a request is in work; results are never held off.
module dependency_topological_sort_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_op,
   input  logic [dts_pkg::IDX_W-1:0]   req_module_index,
   input  logic [dts_pkg::MASK_W-1:0]  req_uses_mask,
   output logic                        rsp_strobe,
   output logic [dts_pkg::IDX_W-1:0]   rsp_module_out,
   output logic                        rsp_last,
   output logic                        rsp_cycle_found,
   output logic [dts_pkg::MASK_W-1:0]  rsp_blocked_mask,
   output logic                        rsp_empty_graph
);
   import dts_pkg::*;

   // sequencer state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;          // sweep counter, top bit marks sweep done
   logic [IDX_W-1:0]  idx_ff, idx_in;          // module being added
   logic [MASK_W-1:0] uses_ff, uses_in;        // its dependencies, self bit removed
   logic [MASK_W-1:0] present_ff, present_in;
   logic [CNT_W-1:0]  order_len_ff, order_len_in;
   logic [IDX_W-1:0]  raddr_ff, raddr_in;      // column read in flight
   logic              rvalid_ff, rvalid_in;
   logic [CNT_W-1:0]  emit_ff, emit_in;
   logic              emit_valid_ff, emit_valid_in;
   logic              emit_last_ff, emit_last_in;

   // result register
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [IDX_W-1:0]  rsp_module_ff, rsp_module_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_cycle_ff, rsp_cycle_in;
   logic [MASK_W-1:0] rsp_blocked_ff, rsp_blocked_in;
   logic              rsp_empty_ff, rsp_empty_in;

   // column store
   logic              em_clear, em_rd_en, em_wr_en;
   logic [IDX_W-1:0]  em_rd_addr, em_wr_addr;
   logic [MASK_W-1:0] em_rd_data, em_wr_data;

   // order buffer
   logic              om_wr_en, om_rd_en;
   logic [IDX_W-1:0]  om_wr_addr, om_wr_data, om_rd_addr, om_rd_data;

   // pending counters
   pend_cmd_type      pcmd;
   logic [MASK_W-1:0] ready, blocked;

   logic              accept;
   logic [IDX_W-1:0]  pick_node;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign pick_node = lowest_set(ready);

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      idx_in         = idx_ff;
      uses_in        = uses_ff;
      present_in     = present_ff;
      order_len_in   = order_len_ff;
      raddr_in       = raddr_ff;
      rvalid_in      = 1'b0;
      emit_in        = emit_ff;
      emit_valid_in  = 1'b0;
      emit_last_in   = emit_last_ff;

      rsp_strobe_in  = 1'b0;
      rsp_module_in  = rsp_module_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_cycle_in   = rsp_cycle_ff;
      rsp_blocked_in = rsp_blocked_ff;
      rsp_empty_in   = rsp_empty_ff;

      em_clear   = 1'b0;
      em_rd_en   = 1'b0;
      em_rd_addr = cnt_ff[IDX_W-1:0];
      em_wr_en   = 1'b0;
      em_wr_addr = raddr_ff;
      em_wr_data = em_rd_data | (MASK_W'(1) << idx_ff);

      om_wr_en   = 1'b0;
      om_wr_addr = order_len_ff[IDX_W-1:0];
      om_wr_data = pick_node;
      om_rd_en   = 1'b0;
      om_rd_addr = emit_ff[IDX_W-1:0];

      pcmd       = '0;
      pcmd.take_node = pick_node;

      // add and count both walk the column store once
      if ((state_ff == S_ADD || state_ff == S_COUNT) && !cnt_ff[CNT_W-1]) begin
         em_rd_en  = 1'b1;
         raddr_in  = cnt_ff[IDX_W-1:0];
         rvalid_in = 1'b1;
         cnt_in    = cnt_ff + 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_ADD: begin
                     // indexes past the live node count are dropped
                     if ({1'b0, req_module_index} < CNT_W'(LIVE_NODES)) begin
                        present_in = present_ff | (MASK_W'(1) << req_module_index);
                        idx_in     = req_module_index;
                        uses_in    = req_uses_mask & ~(MASK_W'(1) << req_module_index);
                        cnt_in     = '0;
                        state_in   = S_ADD;
                     end
                  end
                  OP_CLEAR: begin
                     present_in   = '0;
                     order_len_in = '0;
                     em_clear     = 1'b1;
                  end
                  OP_SORT: begin
                     if (present_ff == '0) begin
                        order_len_in   = '0;
                        rsp_strobe_in  = 1'b1;
                        rsp_module_in  = '0;
                        rsp_last_in    = 1'b1;
                        rsp_cycle_in   = 1'b0;
                        rsp_blocked_in = '0;
                        rsp_empty_in   = 1'b1;
                     end else begin
                        pcmd.init = 1'b1;
                        cnt_in    = '0;
                        state_in  = S_COUNT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD: begin
            // set this module's bit in each used column, one entry behind the read
            em_wr_en = rvalid_ff && uses_ff[raddr_ff];
            if (cnt_ff[CNT_W-1]) state_in = S_IDLE;
         end
         S_COUNT: begin
            pcmd.count_en = rvalid_ff;
            if (cnt_ff[CNT_W-1]) state_in = S_SEED;
         end
         S_SEED: begin
            pcmd.seed    = 1'b1;
            order_len_in = '0;
            state_in     = S_PICK;
         end
         S_PICK: begin
            if (ready == '0) begin
               state_in = S_FINISH;
            end else begin
               pcmd.take_en = 1'b1;
               om_wr_en     = 1'b1;
               order_len_in = order_len_ff + 1'b1;
               em_rd_en     = 1'b1;
               em_rd_addr   = pick_node;
               raddr_in     = pick_node;
               rvalid_in    = 1'b1;
               state_in     = S_RELEASE;
            end
         end
         S_RELEASE: begin
            // users of the picked module lose one pending dependency
            pcmd.release_en = rvalid_ff;
            state_in        = S_PICK;
         end
         S_FINISH: begin
            if (blocked != '0) begin
               rsp_strobe_in  = 1'b1;
               rsp_module_in  = '0;
               rsp_last_in    = 1'b1;
               rsp_cycle_in   = 1'b1;
               rsp_blocked_in = blocked;
               rsp_empty_in   = 1'b0;
               state_in       = S_IDLE;
            end else begin
               emit_in  = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            om_rd_en      = 1'b1;
            emit_valid_in = 1'b1;
            emit_last_in  = (CNT_W'(emit_ff + 1'b1) == order_len_ff);
            emit_in       = emit_ff + 1'b1;
            if (emit_last_in) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            // last buffered index reaches the result register here
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // buffered order read lands in the cycle after issue
      if (emit_valid_ff) begin
         rsp_strobe_in  = 1'b1;
         rsp_module_in  = om_rd_data;
         rsp_last_in    = emit_last_ff;
         rsp_cycle_in   = 1'b0;
         rsp_blocked_in = '0;
         rsp_empty_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         present_ff    <= '0;
         order_len_ff  <= '0;
         rvalid_ff     <= 1'b0;
         emit_ff       <= '0;
         emit_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         present_ff    <= present_in;
         order_len_ff  <= order_len_in;
         rvalid_ff     <= rvalid_in;
         emit_ff       <= emit_in;
         emit_valid_ff <= emit_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      uses_ff        <= uses_in;
      raddr_ff       <= raddr_in;
      emit_last_ff   <= emit_last_in;
      rsp_module_ff  <= rsp_module_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_cycle_ff   <= rsp_cycle_in;
      rsp_blocked_ff <= rsp_blocked_in;
      rsp_empty_ff   <= rsp_empty_in;
   end

   dts_edge_mem u_edge_mem (
      .clock     (clock),
      .reset     (reset),
      .clear_all (em_clear),
      .rd_en     (em_rd_en),
      .rd_addr   (em_rd_addr),
      .rd_data   (em_rd_data),
      .wr_en     (em_wr_en),
      .wr_addr   (em_wr_addr),
      .wr_data   (em_wr_data)
   );

   dts_order_mem u_order_mem (
      .clock   (clock),
      .wr_en   (om_wr_en),
      .wr_addr (om_wr_addr),
      .wr_data (om_wr_data),
      .rd_en   (om_rd_en),
      .rd_addr (om_rd_addr),
      .rd_data (om_rd_data)
   );

   dts_pending u_pending (
      .clock   (clock),
      .reset   (reset),
      .cmd     (pcmd),
      .present (present_ff),
      .row     (em_rd_data),
      .ready   (ready),
      .blocked (blocked)
   );

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_module_out   = rsp_module_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_cycle_found  = rsp_cycle_ff;
   assign rsp_blocked_mask = rsp_blocked_ff;
   assign rsp_empty_graph  = rsp_empty_ff;

   `DTS_ASSERT(a_cycle_has_blocked, rsp_strobe_ff && rsp_cycle_ff |-> rsp_blocked_ff != '0, "cycle result without blocked modules")
   `DTS_ASSERT(a_order_fits, order_len_ff <= CNT_W'(SLOTS), "order length past buffer depth")
   `DTS_ASSERT(a_order_unbroken, rsp_strobe_ff && !rsp_last_ff |=> rsp_strobe_ff, "gap inside an order run")
   `DTS_ASSERT(a_status_is_last, rsp_strobe_ff && (rsp_cycle_ff || rsp_empty_ff) |-> rsp_last_ff, "status result not marked last")

endmodule

// ===== design/dts_edge_mem.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Column store: entry j holds the modules that use module j.
// Per-entry valid bits give the all-zero reset and a clear that empties every entry at once.
module dts_edge_mem (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear_all,
   input  logic                        rd_en,
   input  logic [dts_pkg::IDX_W-1:0]   rd_addr,
   output logic [dts_pkg::MASK_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [dts_pkg::IDX_W-1:0]   wr_addr,
   input  logic [dts_pkg::MASK_W-1:0]  wr_data
);
   import dts_pkg::*;

   logic [MASK_W-1:0] users_ff [SLOTS];
   logic [SLOTS-1:0]  valid_ff, valid_in;
   logic [MASK_W-1:0] rd_data_ff;
   logic              rd_live_ff;

   always_comb begin
      valid_in = valid_ff;
      if (clear_all) begin
         valid_in = '0;
      end else if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         users_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= users_ff[rd_addr];
         rd_live_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_live_ff ? rd_data_ff : '0;

   `DTS_ASSERT(a_no_rw_same_entry, rd_en && wr_en |-> rd_addr != wr_addr, "read and write hit one entry")
   `DTS_ASSERT(a_clear_alone, clear_all |-> !wr_en && !rd_en, "clear overlaps an access")
   `DTS_ASSERT(a_write_marks_valid, wr_en |=> valid_ff[$past(wr_addr)], "written entry not valid")

endmodule

// ===== design/dts_order_mem.sv =====
`timescale 1ns / 1ps

// Order buffer: one module index per emitted slot, registered read.
module dts_order_mem (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [dts_pkg::IDX_W-1:0]  wr_addr,
   input  logic [dts_pkg::IDX_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [dts_pkg::IDX_W-1:0]  rd_addr,
   output logic [dts_pkg::IDX_W-1:0]  rd_data
);
   import dts_pkg::*;

   logic [IDX_W-1:0] order_ff [SLOTS];
   logic [IDX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         order_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= order_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dts_pending.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Pending dependency counters and ready set, updated a whole column at a time.
module dts_pending (
   input  logic                        clock,
   input  logic                        reset,
   input  dts_pkg::pend_cmd_type       cmd,
   input  logic [dts_pkg::MASK_W-1:0]  present,
   input  logic [dts_pkg::MASK_W-1:0]  row,
   output logic [dts_pkg::MASK_W-1:0]  ready,
   output logic [dts_pkg::MASK_W-1:0]  blocked
);
   import dts_pkg::*;

   logic [CNT_W-1:0]  pend_ff [SLOTS];
   logic [CNT_W-1:0]  pend_in [SLOTS];
   logic [MASK_W-1:0] ready_ff, ready_in;
   logic [MASK_W-1:0] zero_vec, freed, take_mask;

   always_comb begin
      freed = '0;
      for (int i = 0; i < SLOTS; i++) begin
         zero_vec[i] = (pend_ff[i] == '0);
         pend_in[i]  = pend_ff[i];
         if (cmd.init) begin
            pend_in[i] = '0;
         end else if (cmd.count_en && present[i] && row[i]) begin
            pend_in[i] = pend_ff[i] + 1'b1;
         end else if (cmd.release_en && present[i] && row[i] && !zero_vec[i]) begin
            pend_in[i] = pend_ff[i] - 1'b1;
            freed[i]   = (pend_ff[i] == CNT_W'(1));
         end
      end
   end

   always_comb begin
      take_mask = cmd.take_en ? (MASK_W'(1) << cmd.take_node) : '0;
      priority if (cmd.init) begin
         ready_in = '0;
      end else if (cmd.seed) begin
         ready_in = present & zero_vec;
      end else begin
         ready_in = (ready_ff & ~take_mask) | freed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= '0;
      end else begin
         ready_ff <= ready_in;
      end
   end

   // counters are rebuilt by every sort before use
   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         pend_ff[i] <= pend_in[i];
      end
   end

   assign ready   = ready_ff;
   assign blocked = present & ~zero_vec;

   `DTS_ASSERT(a_take_is_ready, cmd.take_en |-> ready_ff[cmd.take_node], "took a module that was not ready")
   `DTS_ASSERT(a_one_phase, $countones({cmd.init, cmd.count_en, cmd.seed, cmd.release_en}) <= 1, "counter phases overlap")
   `DTS_ASSERT(a_seed_present, cmd.seed |=> (ready_ff & ~$past(present)) == '0, "absent module seeded ready")

endmodule

// ===== test/dts_order_checker.sv =====
`timescale 1ns / 1ps

// Watches the request and result ports, keeps its own copy of the graph,
// predicts every sort answer and compares the results in order.
module dts_order_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [1:0]                 req_op,
   input  logic [dts_pkg::IDX_W-1:0]  req_module_index,
   input  logic [dts_pkg::MASK_W-1:0] req_uses_mask,
   input  logic                       rsp_strobe,
   input  logic [dts_pkg::IDX_W-1:0]  rsp_module_out,
   input  logic                       rsp_last,
   input  logic                       rsp_cycle_found,
   input  logic [dts_pkg::MASK_W-1:0] rsp_blocked_mask,
   input  logic                       rsp_empty_graph,
   output int                         fail_count,
   output int                         open_count
);
   import dts_pkg::*;

   // far more than one sort can leave outstanding
   localparam int RING_DEPTH = 64;

   typedef struct packed {
      logic [IDX_W-1:0]  module_out;
      logic              last;
      logic              cycle_found;
      logic [MASK_W-1:0] blocked_mask;
      logic              empty_graph;
   } order_result_type;

   logic [MASK_W-1:0] declared_mask;
   logic [MASK_W-1:0] uses_row [SLOTS];
   order_result_type  expected_ring [RING_DEPTH];
   int                exp_head = 0;
   int                exp_tail = 0;
   order_result_type  head;
   int                mismatches = 0;

   function automatic order_result_type make_result(input logic [IDX_W-1:0] mod,
                                                    input logic last,
                                                    input logic cyc,
                                                    input logic [MASK_W-1:0] blocked,
                                                    input logic empty);
      order_result_type r;
      r.module_out   = mod;
      r.last         = last;
      r.cycle_found  = cyc;
      r.blocked_mask = blocked;
      r.empty_graph  = empty;
      return r;
   endfunction

   task automatic add_expected(input order_result_type r);
      expected_ring[exp_tail % RING_DEPTH] = r;
      exp_tail++;
   endtask

   // Kahn pass over the current graph, lowest ready module first
   task automatic queue_sort_results();
      logic [CNT_W-1:0]  waiting [SLOTS];
      logic [MASK_W-1:0] ready;
      logic [MASK_W-1:0] stuck;
      logic [IDX_W-1:0]  taken [SLOTS];
      int                taken_n;
      int                node;
      if (declared_mask == '0) begin
         add_expected(make_result('0, 1'b1, 1'b0, '0, 1'b1));
         return;
      end
      taken_n = 0;
      ready = '0;
      for (int i = 0; i < SLOTS; i++) begin
         waiting[i] = '0;
         if (i < LIVE_NODES && declared_mask[i]) begin
            waiting[i] = CNT_W'($countones(uses_row[i]));
            if (waiting[i] == '0) ready[i] = 1'b1;
         end
      end
      while (ready != '0 && taken_n < SLOTS) begin
         node = 0;
         while (node < LIVE_NODES && !ready[node]) node++;
         if (node >= LIVE_NODES) break;
         ready[node] = 1'b0;
         taken[taken_n] = IDX_W'(node);
         taken_n++;
         for (int i = 0; i < LIVE_NODES; i++) begin
            if (declared_mask[i] && uses_row[i][node] && waiting[i] != '0) begin
               waiting[i] = waiting[i] - 1'b1;
               if (waiting[i] == '0) ready[i] = 1'b1;
            end
         end
      end
      stuck = '0;
      for (int i = 0; i < LIVE_NODES; i++)
         if (declared_mask[i] && waiting[i] != '0) stuck[i] = 1'b1;
      if (stuck != '0) begin
         add_expected(make_result('0, 1'b1, 1'b1, stuck, 1'b0));
      end else begin
         for (int k = 0; k < taken_n; k++)
            add_expected(make_result(taken[k], k == taken_n - 1, 1'b0, '0, 1'b0));
      end
   endtask

   task automatic check_field(input string name, input logic [MASK_W-1:0] want,
                              input logic [MASK_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         declared_mask = '0;
         for (int i = 0; i < SLOTS; i++) uses_row[i] = '0;
         exp_head = 0;
         exp_tail = 0;
      end else begin
         // results first: anything strobed now belongs to an earlier request
         if (rsp_strobe !== 1'b0) begin
            if (exp_tail == exp_head) begin
               $display("%0t: unexpected result, expected none, %s %0h %0h %0h %0h %0h",
                        $time, "actual mod/last/cyc/blk/empty", rsp_module_out,
                        rsp_last, rsp_cycle_found, rsp_blocked_mask, rsp_empty_graph);
               mismatches++;
            end else begin
               head = expected_ring[exp_head % RING_DEPTH];
               exp_head++;
               check_field("module_out", MASK_W'(head.module_out),
                           MASK_W'(rsp_module_out));
               check_field("last", MASK_W'(head.last), MASK_W'(rsp_last));
               check_field("cycle_found", MASK_W'(head.cycle_found),
                           MASK_W'(rsp_cycle_found));
               check_field("blocked_mask", head.blocked_mask, rsp_blocked_mask);
               check_field("empty_graph", MASK_W'(head.empty_graph),
                           MASK_W'(rsp_empty_graph));
            end
         end
         if (start && !busy) begin
            case (op_type'(req_op))
               OP_ADD: begin
                  if (req_module_index < LIVE_NODES) begin
                     uses_row[req_module_index] = uses_row[req_module_index] |
                        (req_uses_mask & ~(MASK_W'(1) << req_module_index));
                     declared_mask[req_module_index] = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  declared_mask = '0;
                  for (int i = 0; i < SLOTS; i++) uses_row[i] = '0;
               end
               OP_SORT: queue_sort_results();
               default: ;
            endcase
         end
      end
      fail_count <= mismatches;
      open_count <= exp_tail - exp_head;
   end

endmodule

// ===== test/tb_dependency_topological_sort_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the dependency sorter. The checker beside the
// block does all prediction and comparison; this module only drives requests.
module tb_dependency_topological_sort_top;
   import dts_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [1:0]        req_op = OP_NONE;
   logic [IDX_W-1:0]  req_module_index = '0;
   logic [MASK_W-1:0] req_uses_mask = '0;
   logic              busy;
   logic              rsp_strobe;
   logic [IDX_W-1:0]  rsp_module_out;
   logic              rsp_last;
   logic              rsp_cycle_found;
   logic [MASK_W-1:0] rsp_blocked_mask;
   logic              rsp_empty_graph;
   int                fail_count;
   int                open_count;

   int requests_sent = 0;   // ignored ops (OP_NONE) are not counted
   int burst_left    = 5;

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   dependency_topological_sort_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_module_index (req_module_index),
      .req_uses_mask    (req_uses_mask),
      .rsp_strobe       (rsp_strobe),
      .rsp_module_out   (rsp_module_out),
      .rsp_last         (rsp_last),
      .rsp_cycle_found  (rsp_cycle_found),
      .rsp_blocked_mask (rsp_blocked_mask),
      .rsp_empty_graph  (rsp_empty_graph)
   );

   dts_order_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_module_index (req_module_index),
      .req_uses_mask    (req_uses_mask),
      .rsp_strobe       (rsp_strobe),
      .rsp_module_out   (rsp_module_out),
      .rsp_last         (rsp_last),
      .rsp_cycle_found  (rsp_cycle_found),
      .rsp_blocked_mask (rsp_blocked_mask),
      .rsp_empty_graph  (rsp_empty_graph),
      .fail_count       (fail_count),
      .open_count       (open_count)
   );

   // Drop start for the requested idle time; the request fields carry junk meanwhile so the
   // block is seen to ignore them without start.
   task automatic idle_for(input int n);
      start            <= 1'b0;
      req_op           <= 2'($urandom_range(0, 3));
      req_module_index <= IDX_W'($urandom);
      req_uses_mask    <= MASK_W'($urandom);
      repeat (n) @(posedge clock);
   endtask

   // One request, held until taken (start && !busy). start stays high into the
   // next request unless the burst ends here. Bursts are mostly short with an
   // occasional long run and no gaps; gaps land anywhere in the block's work
   // since add and sort take very different times.
   task automatic send(input op_type op, input logic [IDX_W-1:0] idx,
                       input logic [MASK_W-1:0] mask);
      req_op           <= op;
      req_module_index <= idx;
      req_uses_mask    <= mask;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      if (op != OP_NONE) requests_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
         idle_for($urandom_range(1, 40));
      end
   endtask

   // Hold off until every predicted result has been seen.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   initial begin
      int                order_of [SLOTS];
      logic [MASK_W-1:0] row_of [SLOTS];
      logic [MASK_W-1:0] mask;
      logic [MASK_W-1:0] split;
      int                graph_size;
      int                density;
      int                first;
      int                p;
      int                j;
      int                tmp;
      int                flavor;
      bit                paused;

      paused = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // sort right after reset: empty graph answer
      send(OP_SORT, '1, '1);
      // unused op code, must be ignored
      send(OP_NONE, 4'hA, 16'h5A5A);
      // top module uses everything, own bit dropped; the others are never
      // declared, so it stays blocked on missing dependencies
      send(OP_ADD, 4'hF, 16'hFFFF);
      send(OP_SORT, '0, '0);
      send(OP_CLEAR, '1, '1);
      // self dependency only: ready at once
      send(OP_ADD, 4'd5, 16'h0020);
      send(OP_ADD, 4'd0, 16'h0000);
      send(OP_ADD, 4'd3, 16'h0001);
      send(OP_ADD, 4'd5, 16'h0008);
      send(OP_SORT, '0, '0);
      // sort leaves the graph as it was: same answer again
      send(OP_SORT, '1, '1);
      send(OP_CLEAR, '0, '0);
      // 4 and 6 form a cycle, 8 sits behind it, 10 is free
      send(OP_ADD, 4'd4, 16'h0040);
      send(OP_ADD, 4'd6, 16'h0010);
      send(OP_ADD, 4'd8, 16'h0010);
      send(OP_ADD, 4'd10, 16'h0000);
      send(OP_SORT, '0, '0);
      // clear then sort: empty again
      send(OP_CLEAR, '0, '0);
      send(OP_SORT, '0, '0);

      // ---- random part ----
      while (requests_sent < 500) begin
         // the sender pauses once mid-run until all results are in
         if (!paused && requests_sent >= 250) begin
            wait_drained();
            paused = 1'b1;
         end
         flavor = $urandom_range(0, 9);
         if (flavor < 2) begin
            // raw noise: any op, any field values
            repeat ($urandom_range(1, 8))
               send(op_type'(2'($urandom_range(0, 3))), IDX_W'($urandom),
                    MASK_W'($urandom));
         end else begin
            // well-formed graph: modules in a random order, each uses only
            // modules earlier in that order, so it sorts unless a broken row follows
            send(OP_CLEAR, IDX_W'($urandom), MASK_W'($urandom));
            for (int i = 0; i < SLOTS; i++) order_of[i] = i;
            for (int i = SLOTS - 1; i > 0; i--) begin
               j = $urandom_range(0, i);
               tmp = order_of[i];
               order_of[i] = order_of[j];
               order_of[j] = tmp;
            end
            graph_size = ($urandom_range(0, 3) == 0) ? SLOTS : $urandom_range(1, SLOTS);
            density = $urandom_range(0, 4);
            for (int i = 0; i < graph_size; i++) begin
               mask = '0;
               for (int q = 0; q < i; q++)
                  if ($urandom_range(0, 3) < density) mask[order_of[q]] = 1'b1;
               // stray self bit, should be dropped
               if ($urandom_range(0, 7) == 0) mask[order_of[i]] = 1'b1;
               row_of[i] = mask;
            end
            // declare from a random starting point; sometimes split a row
            // across two adds to exercise the OR
            first = $urandom_range(0, graph_size - 1);
            for (int k = 0; k < graph_size; k++) begin
               p = (first + k) % graph_size;
               if ($urandom_range(0, 4) == 0) begin
                  split = MASK_W'($urandom);
                  send(OP_ADD, IDX_W'(order_of[p]), row_of[p] & split);
                  send(OP_ADD, IDX_W'(order_of[p]), row_of[p] & ~split);
               end else begin
                  send(OP_ADD, IDX_W'(order_of[p]), row_of[p]);
               end
            end
            // broken graphs: random row, dependency on an absent module or
            // a back edge that can close a cycle
            if (flavor < 4) begin
               p = $urandom_range(0, graph_size - 1);
               case ($urandom_range(0, 2))
                  0: mask = MASK_W'($urandom);
                  1: mask = MASK_W'(1) << $urandom_range(0, SLOTS - 1);
                  default: begin
                     mask = '0;
                     if (graph_size < SLOTS)
                        mask[order_of[$urandom_range(graph_size, SLOTS - 1)]] = 1'b1;
                     else
                        mask[order_of[SLOTS - 1]] = 1'b1;
                  end
               endcase
               send(OP_ADD, IDX_W'(order_of[p]), mask);
            end
            if ($urandom_range(0, 5) == 0)
               send(OP_NONE, IDX_W'($urandom), MASK_W'($urandom));
            send(OP_SORT, IDX_W'($urandom), MASK_W'($urandom));
            if ($urandom_range(0, 3) == 0)
               send(OP_SORT, IDX_W'($urandom), MASK_W'($urandom));
         end
      end

      // all requests taken: let results drain, then give the block time to
      // show any stray result
      wait_drained();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && open_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
